>>> rtl/spd_pkg.sv
// Shared types and constants of the slotted page directory.
`default_nettype none
package spd_pkg;
    localparam int PAGE_SIZE_D = 4096;
    localparam int MAX_SLOTS_D = 64;
    localparam int HEADER_SIZE_D = 24;
    localparam int ENTRY_BYTES = 8;
    localparam int MAX_PAYLOAD_D = 4000;
    localparam logic [15:0] GEN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_GET    = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_SCAN   = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_END     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SL_FREE = 2'd0,
        SL_OCC  = 2'd1,
        SL_RET  = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] gen;
        logic [12:0] offset;
        logic [12:0] length;
    } entry_t;
endpackage
`default_nettype wire

>>> rtl/slotted_page_directory_unit.sv
// Top level of the slotted page directory: sequencer walking the directory memory.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_action s_record_length s_slot_index s_generation
//  m_      | out       | m_valid m_ready m_status m_slot_number ... m_last
//
// A get reads its entry in S_RDREQ and S_RDCHK and then registers its result; insert
// and scan walk the directory, reading each entry through the single registered read
// port in S_RDREQ and S_RDCHK. Erase checks the handle and rewrites it in S_WRITE and
// S_EMIT, then reads every entry, moves each live record in S_WRITE and S_EMIT after
// releasing the previous move, and ends in S_ERFIN. Clear, unknown actions, inserts of
// bad length and scans past slot_total answer from S_IDLE; the contents of entries at or
// past slot_total are never used. Reset is synchronous on aresetn. s_ready stays low
// until the last result is accepted, and a stalled m_ready holds the sequencer.
`default_nettype none
module slotted_page_directory_unit
    import spd_pkg::*;
#(
    parameter int PAGE_SIZE   = PAGE_SIZE_D,
    parameter int MAX_SLOTS   = MAX_SLOTS_D,
    parameter int HEADER_SIZE = HEADER_SIZE_D,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_D
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [11:0] s_record_length,
    input  wire logic [15:0] s_slot_index,
    input  wire logic [15:0] s_generation,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [6:0]       m_slot_number,
    output logic [15:0]      m_slot_generation_out,
    output logic [12:0]      m_record_offset,
    output logic [11:0]      m_length_out,
    output logic [12:0]      m_old_offset,
    output logic [6:0]       m_next_position,
    output logic             m_last
);
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [16:0] PAGE_W = 17'(PAGE_SIZE);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RDREQ = 6'b000010,
        S_RDCHK = 6'b000100,
        S_WRITE = 6'b001000,
        S_EMIT  = 6'b010000,
        S_ERFIN = 6'b100000
    } fsm_t;

    fsm_t        state_reg;
    logic [2:0]  act_reg;
    logic [11:0] len_reg;
    logic [15:0] slot_reg;
    logic [15:0] gen_reg;
    logic [6:0]  idx_reg;
    logic [6:0]  slot_total_reg, live_total_reg;
    logic [16:0] free_low_reg, free_high_reg, cursor_reg;
    logic        erase_phase_reg;
    logic        any_move_reg;
    logic        hold_valid_reg;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t      wr_data, rd_data;

    spd_dir_mem #(.MAX_SLOTS(MAX_SLOTS)) u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign s_ready = (state_reg == S_IDLE) && !m_valid;
    assign rd_addr = idx_reg[AW-1:0];

    logic in_range;
    assign in_range = ({1'b0, idx_reg} < {1'b0, slot_total_reg});

    logic [16:0] avail;
    assign avail = (free_high_reg > free_low_reg) ? free_high_reg - free_low_reg : 17'd0;

    logic handle_ok;
    assign handle_ok = (slot_reg < {9'd0, slot_total_reg}) && (gen_reg != 16'd0)
                       && (rd_data.state == SL_OCC) && (rd_data.gen == gen_reg);

    logic [16:0] new_cursor;
    assign new_cursor = (cursor_reg >= {4'd0, rd_data.length})
                        ? cursor_reg - {4'd0, rd_data.length} : 17'd0;

    task automatic put(input logic [1:0] st, input logic [6:0] sl, input logic [15:0] g,
                       input logic [12:0] off, input logic [11:0] ln, input logic [12:0] old,
                       input logic [6:0] nx, input logic lst);
        m_status <= st; m_slot_number <= sl; m_slot_generation_out <= g;
        m_record_offset <= off; m_length_out <= ln; m_old_offset <= old;
        m_next_position <= nx; m_last <= lst;
    endtask

    always_comb begin
        wr_en = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        if (state_reg == S_WRITE) begin
            wr_en = 1'b1;
            unique case (act_reg)
                ACT_INSERT: begin
                    wr_data.state  = SL_OCC;
                    wr_data.gen    = (in_range) ? rd_data.gen + 16'd1 : 16'd1;
                    wr_data.offset = 13'(free_high_reg - {5'd0, len_reg});
                    wr_data.length = {1'b0, len_reg};
                end
                ACT_ERASE: begin
                    if (!erase_phase_reg) begin
                        wr_data.state  = (rd_data.gen == GEN_MAX) ? SL_RET : SL_FREE;
                        wr_data.offset = 13'd0;
                        wr_data.length = 13'd0;
                    end else begin
                        wr_data.offset = 13'(new_cursor);
                    end
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid <= 1'b0;
            slot_total_reg <= 7'd0;
            live_total_reg <= 7'd0;
            free_low_reg <= 17'(HEADER_SIZE);
            free_high_reg <= PAGE_W;
            idx_reg <= 7'd0;
            erase_phase_reg <= 1'b0;
            any_move_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    act_reg <= s_action; len_reg <= s_record_length;
                    slot_reg <= s_slot_index; gen_reg <= s_generation;
                    erase_phase_reg <= 1'b0; any_move_reg <= 1'b0;
                    cursor_reg <= PAGE_W;
                    unique case (s_action)
                        ACT_INSERT: begin
                            if (s_record_length == 12'd0 ||
                                {5'd0, s_record_length} > 17'(MAX_PAYLOAD)) begin
                                put(ST_INVALID, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                                m_valid <= 1'b1;
                            end else begin
                                idx_reg <= 7'd0; state_reg <= S_RDREQ;
                            end
                        end
                        ACT_GET, ACT_ERASE: begin
                            idx_reg <= (s_slot_index < 16'(MAX_SLOTS)) ? s_slot_index[6:0] : 7'd0;
                            state_reg <= S_RDREQ;
                        end
                        ACT_SCAN: begin
                            if (s_slot_index > {9'd0, slot_total_reg}) begin
                                put(ST_INVALID, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0,
                                    s_slot_index[6:0], 1'b1);
                                m_valid <= 1'b1;
                            end else begin
                                idx_reg <= s_slot_index[6:0]; state_reg <= S_RDREQ;
                            end
                        end
                        ACT_CLEAR: begin
                            slot_total_reg <= 7'd0; live_total_reg <= 7'd0;
                            free_low_reg <= 17'(HEADER_SIZE); free_high_reg <= PAGE_W;
                            put(ST_OK, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                            m_valid <= 1'b1;
                        end
                        default: begin
                            put(ST_INVALID, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                            m_valid <= 1'b1;
                        end
                    endcase
                end
                S_RDREQ: state_reg <= S_RDCHK;
                S_RDCHK: begin
                    unique case (act_reg)
                        ACT_INSERT: begin
                            if (in_range && rd_data.state == SL_FREE && rd_data.gen != GEN_MAX) begin
                                if (avail < {5'd0, len_reg}) begin
                                    put(ST_NOSPACE, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                                    m_valid <= 1'b1; state_reg <= S_IDLE;
                                end else state_reg <= S_WRITE;
                            end else if (in_range) begin
                                idx_reg <= idx_reg + 7'd1; state_reg <= S_RDREQ;
                            end else if ({1'b0, slot_total_reg} >= 8'(MAX_SLOTS) ||
                                         avail < {5'd0, len_reg} + 17'(ENTRY_BYTES)) begin
                                put(ST_NOSPACE, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                                m_valid <= 1'b1; state_reg <= S_IDLE;
                            end else state_reg <= S_WRITE;
                        end
                        ACT_GET: begin
                            if (handle_ok)
                                put(ST_OK, slot_reg[6:0], rd_data.gen, rd_data.offset,
                                    rd_data.length[11:0], 13'd0, 7'd0, 1'b1);
                            else
                                put(ST_INVALID, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                            m_valid <= 1'b1; state_reg <= S_IDLE;
                        end
                        ACT_SCAN: begin
                            if (!in_range) begin
                                put(ST_END, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, slot_total_reg, 1'b1);
                                m_valid <= 1'b1; state_reg <= S_IDLE;
                            end else if (rd_data.state == SL_OCC) begin
                                put(ST_OK, idx_reg, rd_data.gen, 13'd0, 12'd0, 13'd0,
                                    idx_reg + 7'd1, 1'b1);
                                m_valid <= 1'b1; state_reg <= S_IDLE;
                            end else begin
                                idx_reg <= idx_reg + 7'd1; state_reg <= S_RDREQ;
                            end
                        end
                        default: begin
                            if (!erase_phase_reg) begin
                                if (handle_ok) state_reg <= S_WRITE;
                                else begin
                                    put(ST_INVALID, 7'd0, 16'd0, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                                    m_valid <= 1'b1; state_reg <= S_IDLE;
                                end
                            end else if (!in_range) begin
                                state_reg <= S_ERFIN;
                            end else if (rd_data.state == SL_OCC) begin
                                if (hold_valid_reg) begin
                                    m_valid <= 1'b1;
                                    hold_valid_reg <= 1'b0;
                                end else if (!m_valid || m_ready) state_reg <= S_WRITE;
                            end else begin
                                idx_reg <= idx_reg + 7'd1; state_reg <= S_RDREQ;
                            end
                        end
                    endcase
                end
                S_WRITE: begin
                    unique case (act_reg)
                        ACT_INSERT: begin
                            if (!in_range) begin
                                slot_total_reg <= slot_total_reg + 7'd1;
                                free_low_reg <= free_low_reg + 17'(ENTRY_BYTES);
                            end
                            live_total_reg <= live_total_reg + 7'd1;
                            free_high_reg <= free_high_reg - {5'd0, len_reg};
                            put(ST_OK, idx_reg, wr_data.gen, wr_data.offset, len_reg,
                                13'd0, 7'd0, 1'b1);
                            m_valid <= 1'b1; state_reg <= S_IDLE;
                        end
                        default: begin
                            if (!erase_phase_reg) begin
                                if (live_total_reg != 7'd0) live_total_reg <= live_total_reg - 7'd1;
                                erase_phase_reg <= 1'b1;
                            end else begin
                                // The move waits in the output register until the walk
                                // shows whether it is the last one.
                                put(ST_OK, idx_reg, rd_data.gen, 13'(new_cursor),
                                    rd_data.length[11:0], rd_data.offset, 7'd0, 1'b0);
                                any_move_reg <= 1'b1;
                                cursor_reg <= new_cursor;
                                hold_valid_reg <= 1'b1;
                                idx_reg <= idx_reg + 7'd1;
                            end
                            if (!erase_phase_reg) idx_reg <= 7'd0;
                            state_reg <= S_EMIT;
                        end
                    endcase
                end
                S_EMIT: state_reg <= S_RDREQ;
                S_ERFIN: begin
                    free_high_reg <= (live_total_reg == 7'd0) ? PAGE_W : cursor_reg;
                    if (!any_move_reg) begin
                        put(ST_OK, slot_reg[6:0], gen_reg, 13'd0, 12'd0, 13'd0, 7'd0, 1'b1);
                    end else begin
                        m_last <= 1'b1;
                        hold_valid_reg <= 1'b0;
                    end
                    m_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg));
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid);
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_status, m_slot_number,
        m_slot_generation_out, m_record_offset, m_length_out, m_old_offset,
        m_next_position, m_last}));
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_total_reg <= slot_total_reg);
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, slot_total_reg} <= 8'(MAX_SLOTS));
endmodule
`default_nettype wire

>>> rtl/spd_dir_mem.sv
// Directory entry memory with one write port and one registered read port.
`default_nettype none
module spd_dir_mem
    import spd_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_D,
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);
    entry_t mem [MAX_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
